// File: rtl/ptd_pkg.sv
package ptd_pkg;

  localparam int PRIO_W = 10;
  localparam int ID_W   = 8;
  localparam int QCNT_W = 5;
  localparam int ERR_W  = 2;

  localparam logic [PRIO_W-1:0] PRIO_RESET = 10'd1023;

  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_QUEUE_FULL = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NEST_FULL = 2'd2;
  localparam logic [ERR_W-1:0] ERR_NO_TASK   = 2'd3;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } q_entry_t;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_INS      = 7'b0000010,
    ST_INS_CMP  = 7'b0000100,
    ST_POP      = 7'b0001000,
    ST_HEAD_RD  = 7'b0010000,
    ST_HEAD_CHK = 7'b0100000,
    ST_OUT      = 7'b1000000
  } state_t;

endpackage

// File: rtl/preemptive_priority_task_dispatch.sv
// steps to the result register: an add shifts each waiting task it goes ahead of, then
//   writes; a finish pops the nest stack; a dropped add or an idle finish does neither;
//   all then read and check the queue head; the last step waits while the previous result
//   still sits in the output register
// throughput: one transaction at a time; in_ready returns as the result is registered
// reset: control, counts and output valid clear; running priority 1023; memories keep data
module preemptive_priority_task_dispatch #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NEST_DEPTH  = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [ptd_pkg::PRIO_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       mode,
  input  logic [ptd_pkg::ID_W-1:0]   task_id,
  input  logic [ptd_pkg::PRIO_W-1:0] priority_req,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       dispatched,
  output logic [ptd_pkg::ID_W-1:0]   dispatched_task,
  output logic [ptd_pkg::PRIO_W-1:0] running_priority,
  output logic [ptd_pkg::QCNT_W-1:0] queue_count,
  output logic [ptd_pkg::ERR_W-1:0]  error_code
);

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int SAW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int NLW = $clog2(NEST_DEPTH + 1);

  localparam logic [QAW:0]   QD_EXT = (QAW+1)'(QUEUE_DEPTH);
  localparam logic [QCW-1:0] QD_CNT = QCW'(QUEUE_DEPTH);
  localparam logic [NLW-1:0] ND_LVL = NLW'(NEST_DEPTH);

  ptd_pkg::q_entry_t qmem [QUEUE_DEPTH];
  logic [ptd_pkg::PRIO_W-1:0] smem [NEST_DEPTH];

  ptd_pkg::state_t state;

  logic [ptd_pkg::ID_W-1:0]   id_r;
  logic [ptd_pkg::PRIO_W-1:0] prio_r;
  logic [QCW-1:0]             j;
  logic [QAW-1:0]             hd;
  logic [QCW-1:0]             cnt;
  logic [NLW-1:0]             nl;
  logic [ptd_pkg::PRIO_W-1:0] cur;
  logic [ptd_pkg::ERR_W-1:0]  err;
  logic                       disp;
  logic [ptd_pkg::ID_W-1:0]   disp_id;

  ptd_pkg::q_entry_t          q_rdata;
  ptd_pkg::q_entry_t          q_wdata;
  logic                       q_we;
  logic [QAW-1:0]             q_waddr;
  logic [QAW-1:0]             q_raddr;
  logic [ptd_pkg::PRIO_W-1:0] s_rdata;
  logic                       s_we;
  logic [SAW-1:0]             s_waddr;
  logic [SAW-1:0]             s_raddr;

  logic                       accept;
  logic                       shift;
  logic                       head_wins;
  logic [QCW-1:0]             jm1;
  logic [QCW-1:0]             jm2;
  logic [NLW-1:0]             nl_m1;
  logic [QAW-1:0]             hd_next;
  logic [QCW+ptd_pkg::QCNT_W-1:0] cnt_wide;

  // logical queue slot to physical address, ring starting at hd
  function automatic logic [QAW-1:0] phys(input logic [QAW-1:0] base,
                                          input logic [QCW-1:0] off);
    logic [QAW:0] s;
    s = (QAW+1)'(base) + (QAW+1)'(off);
    if (s >= QD_EXT) begin
      s = s - QD_EXT;
    end
    return s[QAW-1:0];
  endfunction

  assign in_ready  = (state == ptd_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign jm1       = j - QCW'(1);
  assign jm2       = j - QCW'(2);
  assign nl_m1     = nl - NLW'(1);
  assign shift     = (q_rdata.prio > prio_r);
  assign head_wins = (q_rdata.prio < cur);
  assign hd_next   = phys(hd, QCW'(1));
  assign cnt_wide  = (QCW+ptd_pkg::QCNT_W)'(cnt);

  always_comb begin
    q_we    = 1'b0;
    q_waddr = phys(hd, j);
    q_wdata = '{prio: prio_r, id: id_r};
    q_raddr = phys(hd, jm1);
    s_we    = 1'b0;
    s_waddr = nl[SAW-1:0];
    s_raddr = nl_m1[SAW-1:0];
    unique case (state)
      ptd_pkg::ST_INS: begin
        q_we = (j == '0);
      end
      ptd_pkg::ST_INS_CMP: begin
        q_we = 1'b1;
        if (shift) begin
          q_wdata = q_rdata;
          q_raddr = phys(hd, jm2);
        end
      end
      ptd_pkg::ST_HEAD_RD: begin
        q_raddr = hd;
      end
      ptd_pkg::ST_HEAD_CHK: begin
        s_we = (cnt != '0) && head_wins && (nl != ND_LVL);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[q_waddr] <= q_wdata;
    end
    q_rdata <= qmem[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_waddr] <= cur;
    end
    s_rdata <= smem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ptd_pkg::ST_IDLE;
      hd        <= '0;
      cnt       <= '0;
      nl        <= '0;
      cur       <= ptd_pkg::PRIO_RESET;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ptd_pkg::ST_OUT)) begin
        out_valid <= 1'b0;
      end
      if (cfg_we && (nl == '0)) begin
        cur <= cfg_wdata;
      end
      unique case (state)
        ptd_pkg::ST_IDLE: begin
          if (accept) begin
            id_r    <= task_id;
            prio_r  <= priority_req;
            j       <= cnt;
            err     <= ptd_pkg::ERR_OK;
            disp    <= 1'b0;
            disp_id <= '0;
            if (mode == ptd_pkg::MODE_ADD) begin
              if (cnt == QD_CNT) begin
                err   <= ptd_pkg::ERR_QUEUE_FULL;
                state <= ptd_pkg::ST_HEAD_RD;
              end else begin
                state <= ptd_pkg::ST_INS;
              end
            end else if (nl == '0) begin
              err   <= ptd_pkg::ERR_NO_TASK;
              state <= ptd_pkg::ST_HEAD_RD;
            end else begin
              nl    <= nl_m1;
              state <= ptd_pkg::ST_POP;
            end
          end
        end
        ptd_pkg::ST_INS: begin
          if (j == '0) begin
            cnt   <= cnt + QCW'(1);
            state <= ptd_pkg::ST_HEAD_RD;
          end else begin
            state <= ptd_pkg::ST_INS_CMP;
          end
        end
        ptd_pkg::ST_INS_CMP: begin
          if (shift) begin
            j <= jm1;
            // the front slot is written without a compare
            if (jm1 == '0) begin
              state <= ptd_pkg::ST_INS;
            end
          end else begin
            cnt   <= cnt + QCW'(1);
            state <= ptd_pkg::ST_HEAD_RD;
          end
        end
        ptd_pkg::ST_POP: begin
          cur   <= s_rdata;
          state <= ptd_pkg::ST_HEAD_RD;
        end
        ptd_pkg::ST_HEAD_RD: begin
          state <= ptd_pkg::ST_HEAD_CHK;
        end
        ptd_pkg::ST_HEAD_CHK: begin
          if ((cnt != '0) && head_wins) begin
            if (nl == ND_LVL) begin
              if (err == ptd_pkg::ERR_OK) begin
                err <= ptd_pkg::ERR_NEST_FULL;
              end
            end else begin
              nl      <= nl + NLW'(1);
              cur     <= q_rdata.prio;
              disp    <= 1'b1;
              disp_id <= q_rdata.id;
              hd      <= hd_next;
              cnt     <= cnt - QCW'(1);
            end
          end
          state <= ptd_pkg::ST_OUT;
        end
        ptd_pkg::ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            dispatched       <= disp;
            dispatched_task  <= disp_id;
            running_priority <= cur;
            queue_count      <= cnt_wide[ptd_pkg::QCNT_W-1:0];
            error_code       <= err;
            state            <= ptd_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= ptd_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/ptd_checker.sv
module ptd_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       dispatched,
  input logic [ptd_pkg::ID_W-1:0]   dispatched_task,
  input logic [ptd_pkg::QCNT_W-1:0] queue_count,
  input logic [ptd_pkg::ERR_W-1:0]  error_code
);

  // a stalled result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(dispatched)
      && $stable(dispatched_task) && $stable(queue_count) && $stable(error_code))
    else $error("result changed while stalled");

  // one transaction in flight at a time
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after a transaction was taken");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !dispatched |-> dispatched_task == '0)
    else $error("task id shown with no dispatch");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == ptd_pkg::ERR_NEST_FULL |-> !dispatched)
    else $error("dispatch reported with nest stack full");

  // a dropped add with no dispatch leaves the queue full
  assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == ptd_pkg::ERR_QUEUE_FULL && !dispatched
      |-> queue_count == ptd_pkg::QCNT_W'(QUEUE_DEPTH))
    else $error("queue full error with queue not full");

endmodule

bind preemptive_priority_task_dispatch ptd_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ptd_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .dispatched      (dispatched),
  .dispatched_task (dispatched_task),
  .queue_count     (queue_count),
  .error_code      (error_code)
);
